[hdl/chkv_pkg.sv]
package chkv_pkg;

  localparam int unsigned CapacityDef  = 256;
  localparam int unsigned ValueBitsDef = 64;
  localparam int unsigned KeyBitsDef   = 64;
  localparam int unsigned NBuckets     = 256;
  localparam logic [31:0] Djb2Start    = 32'd5381;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_UPDATE = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_NEXT   = 2'd3;

  localparam logic [1:0] FLAG_ANY     = 2'd0;
  localparam logic [1:0] FLAG_NOEXIST = 2'd1;
  localparam logic [1:0] FLAG_EXIST   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_KEYB    = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;
  localparam logic [1:0] REG_BUCKETS = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic        has_key;
    logic [63:0] write_value;
    logic [1:0]  update_flag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_value;
    logic [63:0] found_key;
  } rsp_t;

endpackage

[hdl/chkv_hash.sv]
module chkv_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  nbytes_i,
  input  logic [8:0]  nbkt_i,
  output logic        done_o,
  output logic [7:0]  bucket_o
);
  import chkv_pkg::*;

  localparam logic [1:0] H_IDLE = 2'd0;
  localparam logic [1:0] H_BYTE = 2'd1;
  localparam logic [1:0] H_DIV  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] h_q, h_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [8:0]  rem_q, rem_d;
  logic        done_q, done_d;
  logic [9:0]  r10;

  // djb2 one byte a cycle, then restoring division one bit a cycle
  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    r10     = {rem_q, h_q[31]};
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          h_d     = Djb2Start;
          cnt_d   = '0;
          state_d = H_BYTE;
        end
      end
      H_BYTE: begin
        h_d = (h_q << 5) + h_q + 32'(key_i[8*cnt_q[2:0] +: 8]);
        if ({1'b0, cnt_q[2:0]} == nbytes_i - 4'd1) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = H_DIV;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      H_DIV: begin
        h_d = h_q << 1;
        if (r10 >= {1'b0, nbkt_i}) rem_d = 9'(r10 - {1'b0, nbkt_i});
        else rem_d = r10[8:0];
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q[7:0];

endmodule

[hdl/chained_hash_key_value_map.sv]
// Chained hash / direct array key-value map.
// Array requests are decided in idle or after a value read. Hash requests hash the key modulo
// the bucket count, read the head, walk the chain, scan slots on insert and buckets on next-key.
// Throughput: one request at a time; busy, if raised, is high until the result strobe.
// Reset: a clearing pass over max(CAPACITY,256) entries zeroes values and used bits, empties heads.
// Results appear on done_o for one cycle; the receiver cannot stall.
module chained_hash_key_value_map #(
  parameter int unsigned CAPACITY   = chkv_pkg::CapacityDef,
  parameter int unsigned VALUE_BITS = chkv_pkg::ValueBitsDef,
  parameter int unsigned KEY_BITS   = chkv_pkg::KeyBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  chkv_pkg::req_t req_i,
  output logic          done_o,
  output chkv_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [8:0]    cfg_data_i
);
  import chkv_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned PTR_W = IDX_W + 1;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);
  localparam int unsigned LW0 = $clog2(CAPACITY + 1);
  localparam int unsigned LW  = (LW0 > 9) ? LW0 : 9;
  localparam int unsigned CLR_N = (CAPACITY > NBuckets) ? CAPACITY : NBuckets;
  localparam int unsigned CW = $clog2(CLR_N + 1);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ARRW   = 5'd2;
  localparam logic [4:0] S_HSTART = 5'd3;
  localparam logic [4:0] S_HASH   = 5'd4;
  localparam logic [4:0] S_HEAD   = 5'd5;
  localparam logic [4:0] S_HEADW  = 5'd6;
  localparam logic [4:0] S_WALK   = 5'd7;
  localparam logic [4:0] S_WALKW  = 5'd8;
  localparam logic [4:0] S_HIT    = 5'd9;
  localparam logic [4:0] S_MISS   = 5'd10;
  localparam logic [4:0] S_FREE   = 5'd11;
  localparam logic [4:0] S_FREEW  = 5'd12;
  localparam logic [4:0] S_LINK   = 5'd13;
  localparam logic [4:0] S_SCAN   = 5'd14;
  localparam logic [4:0] S_SCANW  = 5'd15;
  localparam logic [4:0] S_NKW    = 5'd16;

  // configuration
  logic       mode_q;
  logic [3:0] kb_q;
  logic [8:0] lim_q, nb_q;
  logic [3:0] ekb;
  logic [8:0] effb;
  logic [LW-1:0] lim;
  logic [63:0] kmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      kb_q   <= 4'd4;
      lim_q  <= 9'd256;
      nb_q   <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:    mode_q <= cfg_data_i[0];
        REG_KEYB:    kb_q   <= cfg_data_i[3:0];
        REG_LIMIT:   lim_q  <= cfg_data_i;
        REG_BUCKETS: nb_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ekb  = (kb_q == 4'd0) ? 4'd1 : ((kb_q > 4'd8) ? 4'd8 : kb_q);
    effb = (nb_q == 9'd0) ? 9'd1 : ((nb_q > 9'd256) ? 9'd256 : nb_q);
    lim  = (LW'(lim_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(lim_q);
    for (int i = 0; i < 64; i++) begin
      kmask[i] = (4'(i / 8) < ekb) && (i < KEY_BITS);
    end
  end

  // memories
  logic [KEY_BITS-1:0]   kmem [CAPACITY];
  logic [VALUE_BITS-1:0] vmem [CAPACITY];
  logic [PTR_W-1:0]      nmem [CAPACITY];
  logic                  umem [CAPACITY];
  logic [PTR_W-1:0]      hmem [NBuckets];

  logic                  k_we, v_we, n_we, u_we, h_we;
  logic [IDX_W-1:0]      k_wa, v_wa, n_wa, u_wa, s_ra, u_ra;
  logic [7:0]            h_wa, h_ra;
  logic [KEY_BITS-1:0]   k_wd, k_rd;
  logic [VALUE_BITS-1:0] v_wd, v_rd;
  logic [PTR_W-1:0]      n_wd, n_rd, h_wd, h_rd;
  logic                  u_wd, u_rd;

  always_ff @(posedge clk_i) begin
    if (k_we) kmem[k_wa] <= k_wd;
    if (v_we) vmem[v_wa] <= v_wd;
    if (n_we) nmem[n_wa] <= n_wd;
    if (u_we) umem[u_wa] <= u_wd;
    if (h_we) hmem[h_wa] <= h_wd;
    k_rd <= kmem[s_ra];
    v_rd <= vmem[s_ra];
    n_rd <= nmem[s_ra];
    u_rd <= umem[u_ra];
    h_rd <= hmem[h_ra];
  end

  // masked key of the request in flight, also hashed
  logic [63:0] key_q, key_d;

  // hash unit
  logic       hstart, hdone;
  logic [7:0] hbucket;

  chkv_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hstart),
    .key_i    (key_q),
    .nbytes_i (ekb),
    .nbkt_i   (effb),
    .done_o   (hdone),
    .bucket_o (hbucket)
  );

  // control
  logic [4:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PTR_W-1:0] cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [7:0]       b_q, b_d;
  logic [LW-1:0]    count_q, count_d;
  logic [1:0]       kind_q, kind_d, flag_q, flag_d;
  logic             hk_q, hk_d;
  logic [VALUE_BITS-1:0] wv_q, wv_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;
  logic [31:0]      aidx;
  logic [32:0]      anx;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    nxt_d   = nxt_q;
    val_d   = val_q;
    b_d     = b_q;
    count_d = count_q;
    kind_d  = kind_q;
    flag_d  = flag_q;
    hk_d    = hk_q;
    key_d   = key_q;
    wv_d    = wv_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    hstart  = 1'b0;
    k_we = 1'b0; v_we = 1'b0; n_we = 1'b0; u_we = 1'b0; h_we = 1'b0;
    k_wa = '0; v_wa = '0; n_wa = '0; u_wa = '0; h_wa = '0;
    k_wd = key_q[KEY_BITS-1:0];
    v_wd = wv_q;
    n_wd = NIL;
    u_wd = 1'b0;
    h_wd = NIL;
    s_ra = '0; u_ra = '0; h_ra = '0;
    aidx = req_i.key[31:0];
    anx  = req_i.has_key ? ({1'b0, aidx} + 33'd1) : 33'd0;

    unique case (state_q)
      S_CLR: begin
        v_wa = cnt_q[IDX_W-1:0];
        v_wd = '0;
        v_we = (cnt_q < CW'(CAPACITY));
        u_wa = cnt_q[IDX_W-1:0];
        u_we = v_we;
        h_wa = cnt_q[7:0];
        h_we = (cnt_q < CW'(NBuckets));
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(CLR_N - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          kind_d = req_i.kind;
          flag_d = req_i.update_flag;
          hk_d   = req_i.has_key;
          key_d  = req_i.key & kmask;
          wv_d   = req_i.write_value[VALUE_BITS-1:0];
          rsp_d  = '0;
          if (!mode_q) begin
            // direct array: decided here, except lookups, which read the value in S_ARRW
            if (req_i.kind == KIND_NEXT) begin
              done_d = 1'b1;
              if (anx >= 33'(lim)) rsp_d.status = ST_NOTFOUND;
              else rsp_d.found_key = 64'(anx);
            end else if (req_i.kind == KIND_DELETE || kb_q != 4'd4) begin
              done_d = 1'b1;
              rsp_d.status = ST_INVALID;
            end else if (aidx >= 32'(lim)) begin
              done_d = 1'b1;
              rsp_d.status = (req_i.kind == KIND_LOOKUP) ? ST_NOTFOUND : ST_FULL;
            end else if (req_i.kind == KIND_LOOKUP) begin
              s_ra    = aidx[IDX_W-1:0];
              state_d = S_ARRW;
            end else begin
              done_d = 1'b1;
              v_we   = 1'b1;
              v_wa   = aidx[IDX_W-1:0];
              v_wd   = req_i.write_value[VALUE_BITS-1:0];
            end
          end else if (req_i.kind == KIND_NEXT && !req_i.has_key) begin
            cnt_d   = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_HSTART;
          end
        end
      end
      S_ARRW: begin
        done_d = 1'b1;
        rsp_d.read_value = 64'(v_rd);
        state_d = S_IDLE;
      end
      S_HSTART: begin
        hstart  = 1'b1;
        state_d = S_HASH;
      end
      S_HASH: begin
        if (hdone) begin
          b_d     = hbucket;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        h_ra    = b_q;
        state_d = S_HEADW;
      end
      S_HEADW: begin
        cur_d   = h_rd;
        prev_d  = NIL;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (cur_q == NIL) begin
          state_d = S_MISS;
        end else begin
          s_ra    = cur_q[IDX_W-1:0];
          state_d = S_WALKW;
        end
      end
      S_WALKW: begin
        if (64'(k_rd) == key_q) begin
          nxt_d   = n_rd;
          val_d   = v_rd;
          state_d = S_HIT;
        end else begin
          prev_d  = cur_q;
          cur_d   = n_rd;
          state_d = S_WALK;
        end
      end
      S_HIT: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        case (kind_q)
          KIND_LOOKUP: rsp_d.read_value = 64'(val_q);
          KIND_UPDATE: begin
            if (flag_q == FLAG_NOEXIST) begin
              rsp_d.status = ST_EXISTS;
            end else begin
              v_we = 1'b1;
              v_wa = cur_q[IDX_W-1:0];
            end
          end
          KIND_DELETE: begin
            // unlink; the freed slot's link is rewritten on reuse
            if (prev_q != NIL) begin
              n_we = 1'b1;
              n_wa = prev_q[IDX_W-1:0];
              n_wd = nxt_q;
            end else begin
              h_we = 1'b1;
              h_wa = b_q;
              h_wd = nxt_q;
            end
            u_we = 1'b1;
            u_wa = cur_q[IDX_W-1:0];
            u_wd = 1'b0;
            if (count_q != '0) count_d = count_q - LW'(1);
          end
          default: begin
            done_d = 1'b0;
            if (nxt_q != NIL) begin
              s_ra    = nxt_q[IDX_W-1:0];
              state_d = S_NKW;
            end else begin
              cnt_d   = CW'(b_q) + CW'(1);
              state_d = S_SCAN;
            end
          end
        endcase
      end
      S_MISS: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (kind_q == KIND_UPDATE) begin
          if (flag_q == FLAG_EXIST) begin
            rsp_d.status = ST_NOTFOUND;
          end else if (count_q >= lim) begin
            rsp_d.status = ST_FULL;
          end else begin
            done_d  = 1'b0;
            cnt_d   = '0;
            state_d = S_FREE;
          end
        end else begin
          rsp_d.status = ST_NOTFOUND;
        end
      end
      S_FREE: begin
        if (cnt_q == CW'(CAPACITY)) begin
          done_d       = 1'b1;
          rsp_d.status = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          u_ra    = cnt_q[IDX_W-1:0];
          state_d = S_FREEW;
        end
      end
      S_FREEW: begin
        if (!u_rd) begin
          u_we = 1'b1; u_wa = cnt_q[IDX_W-1:0]; u_wd = 1'b1;
          k_we = 1'b1; k_wa = cnt_q[IDX_W-1:0];
          v_we = 1'b1; v_wa = cnt_q[IDX_W-1:0];
          n_we = 1'b1; n_wa = cnt_q[IDX_W-1:0]; n_wd = NIL;
          cur_d   = PTR_W'(cnt_q);
          state_d = S_LINK;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_FREE;
        end
      end
      S_LINK: begin
        // append at the chain tail
        if (prev_q != NIL) begin
          n_we = 1'b1;
          n_wa = prev_q[IDX_W-1:0];
          n_wd = cur_q;
        end else begin
          h_we = 1'b1;
          h_wa = b_q;
          h_wd = cur_q;
        end
        count_d = count_q + LW'(1);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (cnt_q >= CW'(effb)) begin
          done_d       = 1'b1;
          rsp_d.status = ST_NOTFOUND;
          state_d      = S_IDLE;
        end else begin
          h_ra    = cnt_q[7:0];
          state_d = S_SCANW;
        end
      end
      S_SCANW: begin
        if (h_rd != NIL) begin
          s_ra    = h_rd[IDX_W-1:0];
          state_d = S_NKW;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_SCAN;
        end
      end
      S_NKW: begin
        done_d          = 1'b1;
        rsp_d.found_key = 64'(k_rd) & kmask;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    nxt_q  <= nxt_d;
    val_q  <= val_d;
    b_q    <= b_d;
    kind_q <= kind_d;
    flag_q <= flag_d;
    hk_q   <= hk_d;
    key_q  <= key_d;
    wv_q   <= wv_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[tb/sv/chkv_checker.sv]
// Watches the request, result and register channels of the key-value map,
// keeps its own copy of the map state and checks every result in order.
module chkv_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  chkv_pkg::req_t  req_i,
  input  logic            done_o,
  input  chkv_pkg::rsp_t  rsp_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [8:0]      cfg_data_i,
  output int              errors_o,
  output int              pending_o
);
  import chkv_pkg::*;

  localparam int Slots = 256;
  localparam int Nil   = Slots;

  // register copies
  logic       map_mode;
  logic [3:0] key_bytes;
  logic [8:0] entry_limit;
  logic [8:0] bucket_count;

  // map contents
  logic [63:0] slot_key   [Slots];
  logic [63:0] slot_value [Slots];
  int          slot_next  [Slots];
  bit          slot_used  [Slots];
  int          bucket_head[NBuckets];
  int          entry_count;

  rsp_t expected_rsps[$];
  int   errors;

  assign errors_o  = errors;
  assign pending_o = expected_rsps.size();

  function automatic int key_len();
    if (key_bytes == 0) return 1;
    if (key_bytes > 8) return 8;
    return key_bytes;
  endfunction

  function automatic logic [63:0] key_mask();
    if (key_len() == 8) return '1;
    return (64'd1 << (8 * key_len())) - 64'd1;
  endfunction

  function automatic int active_limit();
    return (entry_limit > Slots) ? Slots : entry_limit;
  endfunction

  function automatic int active_buckets();
    if (bucket_count == 0) return 1;
    if (bucket_count > NBuckets) return NBuckets;
    return bucket_count;
  endfunction

  function automatic int bucket_of(logic [63:0] k);
    logic [31:0] h;
    h = Djb2Start;
    for (int i = 0; i < key_len(); i++) h = (h << 5) + h + k[8*i +: 8];
    return h % active_buckets();
  endfunction

  // chain walk: slot holding k or Nil, with predecessor (Nil at head)
  function automatic int find_in_chain(int b, logic [63:0] k, output int prev);
    int cur;
    cur  = bucket_head[b];
    prev = Nil;
    for (int n = 0; n < Slots && cur < Slots; n++) begin
      if (slot_key[cur] == k) return cur;
      prev = cur;
      cur  = slot_next[cur];
    end
    return Nil;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    logic [32:0] nx;
    logic [31:0] idx;
    logic [63:0] k;
    int          b, s, prev, fr, first;
    bit          done;
    o   = '0;
    o.status = ST_OK;
    if (!map_mode) begin
      idx = r.key[31:0];
      if (r.kind == KIND_NEXT) begin
        nx = r.has_key ? {1'b0, idx} + 33'd1 : 33'd0;
        if (nx >= active_limit()) o.status = ST_NOTFOUND;
        else o.found_key = {31'd0, nx};
      end else if (r.kind == KIND_DELETE || key_bytes != 4) begin
        o.status = ST_INVALID;
      end else if (idx >= active_limit()) begin
        o.status = (r.kind == KIND_LOOKUP) ? ST_NOTFOUND : ST_FULL;
      end else if (r.kind == KIND_LOOKUP) begin
        o.read_value = slot_value[idx];
      end else begin
        slot_value[idx] = r.write_value;
      end
      return o;
    end
    k = r.key & key_mask();
    b = bucket_of(k);
    if (r.kind == KIND_NEXT) begin
      first = 0;
      done  = 0;
      if (r.has_key) begin
        s = find_in_chain(b, k, prev);
        if (s == Nil) begin
          o.status = ST_NOTFOUND;
          done = 1;
        end else if (slot_next[s] < Slots) begin
          o.found_key = slot_key[slot_next[s]] & key_mask();
          done = 1;
        end else begin
          first = b + 1;
        end
      end
      if (!done) begin
        o.status = ST_NOTFOUND;
        for (int i = first; i < active_buckets(); i++) begin
          if (bucket_head[i] < Slots) begin
            o.found_key = slot_key[bucket_head[i]] & key_mask();
            o.status = ST_OK;
            break;
          end
        end
      end
      return o;
    end
    s = find_in_chain(b, k, prev);
    case (r.kind)
      KIND_LOOKUP: begin
        if (s == Nil) o.status = ST_NOTFOUND;
        else o.read_value = slot_value[s];
      end
      KIND_DELETE: begin
        if (s == Nil) begin
          o.status = ST_NOTFOUND;
        end else begin
          if (prev < Slots) slot_next[prev] = slot_next[s];
          else bucket_head[b] = slot_next[s];
          slot_used[s] = 0;
          slot_next[s] = Nil;
          if (entry_count > 0) entry_count--;
        end
      end
      default: begin
        if (s != Nil) begin
          if (r.update_flag == FLAG_NOEXIST) o.status = ST_EXISTS;
          else slot_value[s] = r.write_value;
        end else if (r.update_flag == FLAG_EXIST) begin
          o.status = ST_NOTFOUND;
        end else if (entry_count >= active_limit()) begin
          o.status = ST_FULL;
        end else begin
          fr = Nil;
          for (int i = 0; i < Slots; i++) begin
            if (!slot_used[i]) begin
              fr = i;
              break;
            end
          end
          if (fr == Nil) begin
            o.status = ST_FULL;
          end else begin
            slot_used[fr]  = 1;
            slot_key[fr]   = k;
            slot_value[fr] = r.write_value;
            slot_next[fr]  = Nil;
            // prev is the tail when the key was not found
            if (prev < Slots) slot_next[prev] = fr;
            else bucket_head[b] = fr;
            entry_count++;
          end
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      map_mode     = 1'b1;
      key_bytes    = 4'd4;
      entry_limit  = 9'd256;
      bucket_count = 9'd256;
      for (int i = 0; i < Slots; i++) begin
        slot_value[i] = '0;
        slot_used[i]  = 0;
        slot_next[i]  = Nil;
      end
      for (int i = 0; i < NBuckets; i++) bucket_head[i] = Nil;
      entry_count = 0;
      expected_rsps.delete();
      errors = 0;
    end else begin
      if (done_o) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, rsp_o);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_o.status !== exp_rsp.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_rsp.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.read_value !== exp_rsp.read_value) begin
            $display("%0t: read_value expected %h got %h", $time, exp_rsp.read_value,
                     rsp_o.read_value);
            errors++;
          end
          if (rsp_o.found_key !== exp_rsp.found_key) begin
            $display("%0t: found_key expected %h got %h", $time, exp_rsp.found_key,
                     rsp_o.found_key);
            errors++;
          end
        end
      end
      if (start && !busy) expected_rsps.push_back(apply_request(req_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:    map_mode     = cfg_data_i[0];
          REG_KEYB:    key_bytes    = cfg_data_i[3:0];
          REG_LIMIT:   entry_limit  = cfg_data_i;
          REG_BUCKETS: bucket_count = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
// Stimulus and verdict for the key-value map. The checker beside the DUT
// does all prediction; this module only drives requests and registers.
module tb_top;
  import chkv_pkg::*;

  localparam int IdleLimit = 20000;  // covers clearing pass and worst scans
  localparam int NumPhases = 11;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  req_t       req_i = '0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_MODE;
  logic [8:0] cfg_data_i = '0;
  logic       busy;
  logic       done_o;
  rsp_t       rsp_o;
  int         errors;
  int         pending;

  // register settings per phase: mode, key bytes, entry limit, buckets, requests
  int phase_mode [NumPhases] = '{1, 1, 1, 0, 0, 0, 1, 1, 1, 0, 1};
  int phase_keyb [NumPhases] = '{4, 8, 1, 4, 4, 7, 0, 15, 2, 4, 3};
  int phase_limit[NumPhases] = '{256, 256, 5, 256, 1, 0, 0, 511, 20, 300, 256};
  int phase_bkts [NumPhases] = '{256, 1, 3, 256, 511, 0, 0, 511, 256, 13, 17};
  int phase_reqs [NumPhases] = '{110, 120, 100, 80, 40, 30, 40, 150, 120, 60, 60};

  logic [63:0] key_pool[16];
  bit          no_gaps;
  int          idle_cycles;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  chained_hash_key_value_map i_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  chkv_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // watchdog: any cycle with a request, result or register write counts as progress
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial idle_cycles = 0;

  function automatic req_t mk_req(logic [1:0] kind, logic [63:0] key, logic has_key,
                                  logic [63:0] wval, logic [1:0] flag);
    req_t r;
    r.kind        = kind;
    r.key         = key;
    r.has_key     = has_key;
    r.write_value = wval;
    r.update_flag = flag;
    return r;
  endfunction

  // hold start until the request is taken, then draw a gap
  task automatic send(input req_t r);
    int gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[8:0];
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t random_req(bit array_mode, int lim);
    logic [63:0] key;
    logic [1:0]  kind;
    int          pick;
    pick = $urandom_range(0, 99);
    if (array_mode) begin
      // mostly in-range indexes, some just past the limit, a few anywhere
      if (pick < 75) key = {rnd64() & 64'hFFFF_FFFF_0000_0000} | $urandom_range(0, lim + 3);
      else if (pick < 90) key = {32'd0, $urandom};
      else key = rnd64();
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? KIND_UPDATE : (pick < 70) ? KIND_LOOKUP :
             (pick < 90) ? KIND_NEXT : KIND_DELETE;
    end else begin
      // mostly keys of a small pool so lookups, deletes and chains hit
      key = (pick < 75) ? key_pool[$urandom_range(0, 15)] : rnd64();
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? KIND_UPDATE : (pick < 65) ? KIND_LOOKUP :
             (pick < 82) ? KIND_DELETE : KIND_NEXT;
    end
    return mk_req(kind, key, $urandom_range(0, 9) != 0, rnd64(),
                  2'($urandom_range(0, 3)));
  endfunction

  initial begin
    logic [63:0] k0, k1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the DUT clears its stores after reset; busy covers that pass
    do @(posedge clk_i); while (busy);

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        start <= 1'b0;
        // pause the sender until the map is idle before touching registers;
        // one edge first so the last request is already counted
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
        write_reg(REG_MODE, phase_mode[p]);
        write_reg(REG_KEYB, phase_keyb[p]);
        write_reg(REG_LIMIT, phase_limit[p]);
        write_reg(REG_BUCKETS, phase_bkts[p]);
        cfg_we_i <= 1'b0;
      end
      foreach (key_pool[i]) key_pool[i] = rnd64();
      no_gaps = (p % 3 == 1);

      if (p == 0) begin
        // directed: extreme keys, every flag, chain walk, deletes, absent keys
        k0 = '0;
        k1 = '1;
        send(mk_req(KIND_NEXT,   k0, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_UPDATE, k0, 1'b0, '1, FLAG_ANY));
        send(mk_req(KIND_UPDATE, k1, 1'b1, 64'h0123_4567_89AB_CDEF, FLAG_NOEXIST));
        send(mk_req(KIND_UPDATE, k1, 1'b0, '0, FLAG_NOEXIST));
        send(mk_req(KIND_UPDATE, 64'h55, 1'b0, '1, FLAG_EXIST));
        send(mk_req(KIND_UPDATE, k1, 1'b0, 64'hAAAA_5555_AAAA_5555, FLAG_EXIST));
        send(mk_req(KIND_UPDATE, 64'h77, 1'b0, 64'h5555_AAAA_5555_AAAA, 2'd3));
        send(mk_req(KIND_LOOKUP, k0, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_LOOKUP, k1, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_LOOKUP, 64'h1234, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT,   k0, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT,   k0, 1'b1, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT,   k1, 1'b1, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT,   64'h77, 1'b1, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT,   64'h9999, 1'b1, '0, FLAG_ANY));
        send(mk_req(KIND_DELETE, k1, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_DELETE, k1, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_LOOKUP, k1, 1'b0, '0, FLAG_ANY));
      end
      if (phase_mode[p] == 0) begin
        // directed array edges: last index, first index, wrap of next key
        send(mk_req(KIND_UPDATE, 64'd255, 1'b0, '1, FLAG_NOEXIST));
        send(mk_req(KIND_LOOKUP, 64'd0, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0, FLAG_ANY));
        send(mk_req(KIND_NEXT, 64'd0, 1'b0, '0, FLAG_ANY));
        send(mk_req(KIND_DELETE, 64'd1, 1'b0, '0, FLAG_ANY));
      end

      for (int n = 0; n < phase_reqs[p]; n++)
        send(random_req(phase_mode[p] == 0, phase_limit[p]));
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
